// ===== sv/clm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_pkg: shared constants, types and step functions for the look-at matrix
// Widths, the normalizer's pipeline depth, and one step of the root and
// quotient recurrences used by the vector normalizer.
// ----------------------------------------------------------------------------
package clm_pkg;

	localparam int COORD_BITS = 32;           // input coordinate width, Q16.16
	localparam int AXIS_W     = 32;           // Q2.30 axis component
	localparam int NORM_W     = 64;           // normalizer input component
	localparam int POS_W      = $clog2(NORM_W);
	localparam int MAG_W      = 30;           // scaled magnitude, top in [2^29, 2^30)
	localparam int Q_FRAC     = 30;           // fraction bits of a unit axis
	localparam int RAD_W      = 2 * MAG_W + 2;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int DD_W       = MAG_W + Q_FRAC + 1;
	localparam int DLO_W      = ROOT_W;
	localparam int DREM_W     = ROOT_W + 1;
	localparam int SQ_STEPS   = ROOT_W;
	localparam int DIV_STEPS  = ROOT_W;
	// s1..s4, radicand, root steps, divider load, quotient steps, output
	localparam int NORM_LAT   = 7 + SQ_STEPS + DIV_STEPS;

	typedef logic [2:0][NORM_W-1:0]     nvec_t;
	typedef logic [2:0][AXIS_W-1:0]     axis_t;
	typedef logic [2:0][COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} nsign_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [DLO_W-1:0]  dlo;
		logic [ROOT_W-1:0] q;
	} dv_t;

	// one digit of the integer square root
	function automatic sq_t sqrt_step(input sq_t a);
		sq_t             r;
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] trial;
		rem2  = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem  = rem2 - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem2;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// one bit of restoring division by len
	function automatic dv_t div_step(input dv_t a, input logic [ROOT_W-1:0] len);
		dv_t               r;
		logic [DREM_W-1:0] rem2;
		rem2  = {a.rem[DREM_W-2:0], a.dlo[DLO_W-1]};
		r.dlo = {a.dlo[DLO_W-2:0], 1'b0};
		if (rem2 >= {1'b0, len}) begin
			r.rem = rem2 - {1'b0, len};
			r.q   = {a.q[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = rem2;
			r.q   = {a.q[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== sv/clm_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_norm: pipelined 3-vector normalizer
// Scales the magnitudes so the largest lies in [2^29, 2^30), takes the root of
// the sum of squares one digit per stage, then divides each component one
// quotient bit per stage with rounding. Zero vector gives zero. One beat/cycle.
// ----------------------------------------------------------------------------
module clm_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  clm_pkg::nvec_t vec_in,
	output logic           vld_out,
	output clm_pkg::axis_t vec_out
);

	localparam int SQ  = clm_pkg::SQ_STEPS;
	localparam int DV  = clm_pkg::DIV_STEPS;
	localparam int MW  = clm_pkg::MAG_W;
	localparam int NW  = clm_pkg::NORM_W;
	localparam int PW  = clm_pkg::POS_W;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0][NW-1:0]            mag_c, mag_s1, mag_s2;
	logic [2:0]                    neg_s1, neg_s2;
	logic [NW-1:0]                 orv;
	logic [PW-1:0]                 pos_c, pos_s2;
	logic                          zero_s2;
	logic [2:0][MW-1:0]            n_c, n_s3, n_s4;
	clm_pkg::nsign_t               sg_s3, sg_s4;
	logic [2:0][2*MW-1:0]          sqr_s4;

	logic                          root_vld [0:SQ];
	clm_pkg::sq_t                  root_s   [0:SQ];
	logic [2:0][MW-1:0]            root_n   [0:SQ];
	clm_pkg::nsign_t               root_sg  [0:SQ];

	logic                          div_vld  [0:DV];
	clm_pkg::dv_t                  div_s    [0:DV][3];
	logic [clm_pkg::ROOT_W-1:0]    div_len  [0:DV];
	clm_pkg::nsign_t               div_sg   [0:DV];

	clm_pkg::dv_t                  div_init [3];
	logic [clm_pkg::DD_W-1:0]      dd_c     [3];
	clm_pkg::axis_t                vec_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec_in[i][NW-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
		end
	end

	// leading one of the OR is the leading one of the largest magnitude
	always_comb begin
		orv   = mag_s1[0] | mag_s1[1] | mag_s1[2];
		pos_c = '0;
		for (int k = 0; k < NW; k++) begin
			if (orv[k]) begin
				pos_c = PW'(k);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(MW - 1)) begin
				n_c[i] = MW'(mag_s2[i] >> (pos_s2 - PW'(MW - 1)));
			end else begin
				n_c[i] = MW'(mag_s2[i] << (PW'(MW - 1) - pos_s2));
			end
		end
	end

	// dividend = m * 2^30 + floor(len / 2)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_c[i] = clm_pkg::DD_W'({root_n[SQ][i], {clm_pkg::Q_FRAC{1'b0}}})
				+ clm_pkg::DD_W'(root_s[SQ].root >> 1);
			div_init[i].rem = clm_pkg::DREM_W'(dd_c[i][clm_pkg::DD_W-1:clm_pkg::DLO_W]);
			div_init[i].dlo = dd_c[i][clm_pkg::DLO_W-1:0];
			div_init[i].q   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int k = 0; k <= SQ; k++) begin
				root_vld[k] <= 1'b0;
			end
			for (int k = 0; k <= DV; k++) begin
				div_vld[k] <= 1'b0;
			end
		end else begin
			vld_s1      <= vld_in;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			root_vld[0] <= vld_s4;
			for (int k = 0; k < SQ; k++) begin
				root_vld[k+1] <= root_vld[k];
			end
			div_vld[0] <= root_vld[SQ];
			for (int k = 0; k < DV; k++) begin
				div_vld[k+1] <= div_vld[k];
			end
			vld_s5 <= div_vld[DV];
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec_in[i][NW-1];
		end
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		pos_s2  <= pos_c;
		zero_s2 <= ~|orv;
		n_s3    <= n_c;
		sg_s3   <= '{zero: zero_s2, neg: neg_s2};
		n_s4    <= n_s3;
		sg_s4   <= sg_s3;
		for (int i = 0; i < 3; i++) begin
			sqr_s4[i] <= n_s3[i] * n_s3[i];
		end
		root_s[0].rad  <= clm_pkg::RAD_W'(sqr_s4[0]) + clm_pkg::RAD_W'(sqr_s4[1])
			+ clm_pkg::RAD_W'(sqr_s4[2]);
		root_s[0].rem  <= '0;
		root_s[0].root <= '0;
		root_n[0]      <= n_s4;
		root_sg[0]     <= sg_s4;
		for (int k = 0; k < SQ; k++) begin
			root_s[k+1]  <= clm_pkg::sqrt_step(root_s[k]);
			root_n[k+1]  <= root_n[k];
			root_sg[k+1] <= root_sg[k];
		end
		for (int i = 0; i < 3; i++) begin
			div_s[0][i] <= div_init[i];
		end
		div_len[0] <= root_s[SQ].root;
		div_sg[0]  <= root_sg[SQ];
		for (int k = 0; k < DV; k++) begin
			for (int i = 0; i < 3; i++) begin
				div_s[k+1][i] <= clm_pkg::div_step(div_s[k][i], div_len[k]);
			end
			div_len[k+1] <= div_len[k];
			div_sg[k+1]  <= div_sg[k];
		end
		for (int i = 0; i < 3; i++) begin
			if (div_sg[DV].zero) begin
				vec_s5[i] <= '0;
			end else if (div_sg[DV].neg[i]) begin
				vec_s5[i] <= ~{1'b0, div_s[DV][i].q} + 1'b1;
			end else begin
				vec_s5[i] <= {1'b0, div_s[DV][i].q};
			end
		end
	end

	assign vld_out = vld_s5;
	assign vec_out = vec_s5;

endmodule

// ===== sv/camera_look_at_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_look_at_matrix: right-handed look-at view matrix, fully pipelined
// back = norm(eye - center), right = norm(up x back), upaxis = back x right,
// offsets = -dot(axis, eye) in saturated Q16.16. Axes in Q2.30.
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------
//  input     | start / busy      | eye_*, center_*, upward_*  (Q16.16)
//  result    | done (one cycle)  | right_*, upaxis_*, back_*, *_offset
//
// One beat is taken every cycle; busy never rises.
// The pipeline depth is set by the two normalizers in series, each a
// one-digit-per-stage root and one-bit-per-stage divider.
// Reset clears only the valid bits; no clearing pass is needed.
// The result appears for exactly one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module camera_look_at_matrix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  eye_x,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  eye_y,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  eye_z,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  center_x,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  center_y,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  center_z,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  upward_x,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  upward_y,
	input  logic signed [clm_pkg::COORD_BITS-1:0]  upward_z,
	output logic                                   done,
	output logic signed [clm_pkg::AXIS_W-1:0]      right_x,
	output logic signed [clm_pkg::AXIS_W-1:0]      right_y,
	output logic signed [clm_pkg::AXIS_W-1:0]      right_z,
	output logic signed [clm_pkg::AXIS_W-1:0]      right_offset,
	output logic signed [clm_pkg::AXIS_W-1:0]      upaxis_x,
	output logic signed [clm_pkg::AXIS_W-1:0]      upaxis_y,
	output logic signed [clm_pkg::AXIS_W-1:0]      upaxis_z,
	output logic signed [clm_pkg::AXIS_W-1:0]      upaxis_offset,
	output logic signed [clm_pkg::AXIS_W-1:0]      back_x,
	output logic signed [clm_pkg::AXIS_W-1:0]      back_y,
	output logic signed [clm_pkg::AXIS_W-1:0]      back_z,
	output logic signed [clm_pkg::AXIS_W-1:0]      back_offset
);

	localparam int CB        = clm_pkg::COORD_BITS;
	localparam int AW        = clm_pkg::AXIS_W;
	localparam int NW        = clm_pkg::NORM_W;
	localparam int LAT       = clm_pkg::NORM_LAT;
	localparam int QF        = clm_pkg::Q_FRAC;
	localparam int PROD_W    = AW + CB;
	localparam int SUM_W     = PROD_W + 2;
	localparam int TW        = SUM_W - QF;
	localparam int TOTAL_LAT = 2 * LAT + 8;

	typedef struct packed {
		clm_pkg::axis_t  back;
		clm_pkg::coord_t eye;
	} side_t;

	function automatic logic [AW-1:0] sat_neg(input logic [TW-1:0] t);
		logic [TW:0] nt;
		nt = ~{t[TW-1], t} + 1'b1;
		if ((&nt[TW:AW-1]) || (~|nt[TW:AW-1])) begin
			return nt[AW-1:0];
		end else if (nt[TW]) begin
			return {1'b1, {(AW-1){1'b0}}};
		end else begin
			return {1'b0, {(AW-1){1'b1}}};
		end
	endfunction

	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                       vld_s6, vld_s7, vld_s8;
	clm_pkg::coord_t            eye_s1, eye_s2, eye_s3, eye_s4, eye_s5;
	clm_pkg::nvec_t             diff_s1, up_s1, wide_s3;
	clm_pkg::coord_t            eye_dl_q [0:LAT-1];
	side_t                      side_dl_q [0:LAT-1];

	logic                       vb, vu, vr;
	clm_pkg::axis_t             back_n, upn_n, right_n;

	logic signed [NW-1:0]       prd_s2 [6];
	logic signed [NW-1:0]       prd_s4 [6];
	logic signed [NW-1:0]       ua_c [3];
	clm_pkg::axis_t             back_s2, back_s3, back_s4, back_s5;
	clm_pkg::axis_t             right_s4, right_s5, upax_s5;
	clm_pkg::axis_t             ax_s6 [3];
	clm_pkg::axis_t             ax_s7 [3];
	clm_pkg::axis_t             ax_s8 [3];
	logic signed [PROD_W-1:0]   dp_s6 [3][3];
	logic signed [SUM_W-1:0]    sum_c [3];
	logic [TW-1:0]              t_s7  [3];
	logic [AW-1:0]              off_s8 [3];

	assign busy = 1'b0;

	clm_norm u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.vec_in  (diff_s1),
		.vld_out (vb),
		.vec_out (back_n)
	);

	clm_norm u_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.vec_in  (up_s1),
		.vld_out (vu),
		.vec_out (upn_n)
	);

	clm_norm u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s3),
		.vec_in  (wide_s3),
		.vld_out (vr),
		.vec_out (right_n)
	);

	// upaxis: Q4.60 cross product rounded to Q2.30, ties up
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ua_c[i] = prd_s4[2*i] - prd_s4[2*i+1] + NW'(64'sd1 <<< (QF - 1));
		end
	end

	// offsets: exact dot in Q18.46, rounded to Q16.16
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_c[a] = SUM_W'(dp_s6[a][0]) + SUM_W'(dp_s6[a][1]) + SUM_W'(dp_s6[a][2])
				+ SUM_W'(64'sd1 <<< (QF - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vb;
			vld_s3 <= vld_s2;
			vld_s4 <= vr;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		eye_s1     <= {eye_z, eye_y, eye_x};
		diff_s1[0] <= NW'($signed({eye_x[CB-1], eye_x}) - $signed({center_x[CB-1], center_x}));
		diff_s1[1] <= NW'($signed({eye_y[CB-1], eye_y}) - $signed({center_y[CB-1], center_y}));
		diff_s1[2] <= NW'($signed({eye_z[CB-1], eye_z}) - $signed({center_z[CB-1], center_z}));
		up_s1[0]   <= NW'(upward_x);
		up_s1[1]   <= NW'(upward_y);
		up_s1[2]   <= NW'(upward_z);

		// eye rides alongside the first normalizers
		eye_dl_q[0] <= eye_s1;
		for (int k = 0; k < LAT - 1; k++) begin
			eye_dl_q[k+1] <= eye_dl_q[k];
		end

		// up x back, full precision
		prd_s2[0] <= $signed(upn_n[1]) * $signed(back_n[2]);
		prd_s2[1] <= $signed(upn_n[2]) * $signed(back_n[1]);
		prd_s2[2] <= $signed(upn_n[2]) * $signed(back_n[0]);
		prd_s2[3] <= $signed(upn_n[0]) * $signed(back_n[2]);
		prd_s2[4] <= $signed(upn_n[0]) * $signed(back_n[1]);
		prd_s2[5] <= $signed(upn_n[1]) * $signed(back_n[0]);
		back_s2   <= back_n;
		eye_s2    <= eye_dl_q[LAT-1];

		for (int i = 0; i < 3; i++) begin
			wide_s3[i] <= prd_s2[2*i] - prd_s2[2*i+1];
		end
		back_s3 <= back_s2;
		eye_s3  <= eye_s2;

		side_dl_q[0] <= '{back: back_s3, eye: eye_s3};
		for (int k = 0; k < LAT - 1; k++) begin
			side_dl_q[k+1] <= side_dl_q[k];
		end

		// back x right
		prd_s4[0] <= $signed(side_dl_q[LAT-1].back[1]) * $signed(right_n[2]);
		prd_s4[1] <= $signed(side_dl_q[LAT-1].back[2]) * $signed(right_n[1]);
		prd_s4[2] <= $signed(side_dl_q[LAT-1].back[2]) * $signed(right_n[0]);
		prd_s4[3] <= $signed(side_dl_q[LAT-1].back[0]) * $signed(right_n[2]);
		prd_s4[4] <= $signed(side_dl_q[LAT-1].back[0]) * $signed(right_n[1]);
		prd_s4[5] <= $signed(side_dl_q[LAT-1].back[1]) * $signed(right_n[0]);
		right_s4  <= right_n;
		back_s4   <= side_dl_q[LAT-1].back;
		eye_s4    <= side_dl_q[LAT-1].eye;

		for (int i = 0; i < 3; i++) begin
			upax_s5[i] <= ua_c[i][QF +: AW];
		end
		right_s5 <= right_s4;
		back_s5  <= back_s4;
		eye_s5   <= eye_s4;

		ax_s6[0] <= right_s5;
		ax_s6[1] <= upax_s5;
		ax_s6[2] <= back_s5;
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < 3; i++) begin
				dp_s6[a][i] <= $signed(a == 0 ? right_s5[i] : (a == 1 ? upax_s5[i] : back_s5[i]))
					* $signed(eye_s5[i]);
			end
		end

		for (int a = 0; a < 3; a++) begin
			t_s7[a]  <= sum_c[a][SUM_W-1:QF];
			ax_s7[a] <= ax_s6[a];
		end

		for (int a = 0; a < 3; a++) begin
			off_s8[a] <= sat_neg(t_s7[a]);
			ax_s8[a]  <= ax_s7[a];
		end
	end

	assign done          = vld_s8;
	assign right_x       = ax_s8[0][0];
	assign right_y       = ax_s8[0][1];
	assign right_z       = ax_s8[0][2];
	assign right_offset  = off_s8[0];
	assign upaxis_x      = ax_s8[1][0];
	assign upaxis_y      = ax_s8[1][1];
	assign upaxis_z      = ax_s8[1][2];
	assign upaxis_offset = off_s8[1];
	assign back_x        = ax_s8[2][0];
	assign back_y        = ax_s8[2][1];
	assign back_z        = ax_s8[2][2];
	assign back_offset   = off_s8[2];

	// the two first-level normalizers run in lockstep
	a_norm_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vb == vu)
		else $error("back and up normalizers out of step");

	a_right_align: assert property (@(posedge clk) disable iff (!arst_n)
		vr |-> $past(vld_s3, LAT))
		else $error("right normalizer beat without a matching cross beat");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result beat without an accepted input beat");

	// eye on center: every axis and offset collapses to zero
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && back_x == 0 && back_y == 0 && back_z == 0) |->
		(right_x == 0 && right_y == 0 && right_z == 0 && upaxis_x == 0 &&
		upaxis_y == 0 && upaxis_z == 0 && right_offset == 0 &&
		upaxis_offset == 0 && back_offset == 0))
		else $error("zero back axis with nonzero result");

endmodule
